// ===== src/cv4a_pkg.sv =====
// Package for the checked four-lane 64-bit vector ALU.
// Types, operation codes and controller commands; no dependencies.
package cv4a_pkg;

    localparam int unsigned LaneW  = 64;
    localparam int unsigned Lanes  = 4;
    localparam int unsigned OpW    = 3;
    localparam int unsigned CntW   = 7;

    localparam logic [OpW-1:0] OP_SET = 3'd0;
    localparam logic [OpW-1:0] OP_ADD = 3'd1;
    localparam logic [OpW-1:0] OP_SUB = 3'd2;
    localparam logic [OpW-1:0] OP_MUL = 3'd3;
    localparam logic [OpW-1:0] OP_DIV = 3'd4;
    localparam logic [OpW-1:0] OP_NEG = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_COMMIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

endpackage

// ===== src/cv4a_datapath.sv =====
// Datapath: accumulator lanes, per-lane shift-add multiplier and restoring
// divider, one bit per step. Depends on cv4a_pkg.
module cv4a_datapath (
    input  logic                             i_clk,
    input  cv4a_pkg::t_cmd                   i_cmd,
    input  logic [cv4a_pkg::OpW-1:0]         i_req_type,
    input  logic [cv4a_pkg::Lanes-1:0][63:0] i_opnd,
    input  logic [cv4a_pkg::Lanes-1:0]       i_keep,
    input  logic                             i_rst_n,
    output cv4a_pkg::t_stat                  o_stat,
    output logic                             o_status,
    output logic [cv4a_pkg::Lanes-1:0][63:0] o_acc
);
    logic [cv4a_pkg::Lanes-1:0][63:0]  r_acc, r_b;
    logic [cv4a_pkg::Lanes-1:0][127:0] r_wk, n_wk;
    logic [cv4a_pkg::Lanes-1:0][63:0]  r_q, n_q;
    logic [cv4a_pkg::Lanes-1:0]        r_neg;
    logic [cv4a_pkg::OpW-1:0]          r_op;
    logic [cv4a_pkg::Lanes-1:0]        r_keep;
    logic [cv4a_pkg::CntW-1:0]         r_cnt;
    logic                              r_status;

    logic [cv4a_pkg::Lanes-1:0][63:0]  ma, mb, res;
    logic [cv4a_pkg::Lanes-1:0]        fl;
    logic                              fail;

    always_comb begin
        for (int i = 0; i < cv4a_pkg::Lanes; i++) begin
            ma[i] = r_acc[i][63] ? 64'(-r_acc[i]) : r_acc[i];
            mb[i] = r_b[i][63] ? 64'(-r_b[i]) : r_b[i];
        end
    end

    // step: mul accumulates ma<<k where bit k of mb (wk = product magnitude),
    // div restores into wk[127:64] with q shifting in.
    always_comb begin
        for (int i = 0; i < cv4a_pkg::Lanes; i++) begin
            logic [64:0] rem;
            n_wk[i] = r_wk[i];
            n_q[i]  = r_q[i];
            rem = 65'd0;
            if (r_op == cv4a_pkg::OP_MUL) begin
                if (mb[i][6'(r_cnt)])
                    n_wk[i] = r_wk[i] + ({64'd0, ma[i]} << r_cnt[5:0]);
            end else begin
                rem = {r_wk[i][127:64], ma[i][6'(7'd63 - r_cnt)]};
                if (rem >= {1'b0, mb[i]}) begin
                    rem = rem - {1'b0, mb[i]};
                    n_q[i] = {r_q[i][62:0], 1'b1};
                end else begin
                    n_q[i] = {r_q[i][62:0], 1'b0};
                end
                n_wk[i] = {rem[63:0], 64'd0};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < cv4a_pkg::Lanes; i++) begin
            logic [63:0] a, b, s;
            a = r_acc[i];
            b = r_b[i];
            res[i] = a;
            fl[i]  = 1'b0;
            s = 64'd0;
            case (r_op)
                cv4a_pkg::OP_SET: res[i] = r_keep[i] ? a : b;
                cv4a_pkg::OP_ADD: begin
                    s = a + b;
                    res[i] = s;
                    fl[i] = (a[63] == b[63]) && (s[63] != a[63]);
                end
                cv4a_pkg::OP_SUB: begin
                    s = a - b;
                    res[i] = s;
                    fl[i] = (a[63] != b[63]) && (s[63] != a[63]);
                end
                cv4a_pkg::OP_MUL: begin
                    res[i] = r_neg[i] ? 64'(-r_wk[i][63:0]) : r_wk[i][63:0];
                    if (r_neg[i])
                        fl[i] = r_wk[i] > 128'h8000000000000000;
                    else
                        fl[i] = r_wk[i] > 128'h7FFFFFFFFFFFFFFF;
                end
                cv4a_pkg::OP_DIV: begin
                    res[i] = r_neg[i] ? 64'(-r_q[i]) : r_q[i];
                    fl[i] = (b == 64'd0) ||
                            (a == 64'h8000000000000000 && b == '1);
                end
                cv4a_pkg::OP_NEG: begin
                    res[i] = 64'(-a);
                    fl[i] = a == 64'h8000000000000000;
                end
                default: fl[i] = 1'b1;
            endcase
        end
        fail = |fl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_status <= 1'b0;
            r_cnt    <= '0;
        end else if (i_cmd.load) begin
            r_op   <= i_req_type;
            r_b    <= i_opnd;
            r_keep <= i_keep;
            r_cnt  <= '0;
            for (int i = 0; i < cv4a_pkg::Lanes; i++) begin
                r_wk[i]  <= '0;
                r_q[i]   <= '0;
                r_neg[i] <= r_acc[i][63] ^ i_opnd[i][63];
            end
        end else if (i_cmd.step) begin
            r_wk  <= n_wk;
            r_q   <= n_q;
            r_cnt <= r_cnt + 7'd1;
        end else if (i_cmd.commit) begin
            r_status <= fail;
            if (!fail)
                r_acc <= res;
        end
    end

    assign o_stat.last = r_cnt == 7'd63;
    assign o_status    = r_status;
    assign o_acc       = r_acc;
endmodule

// ===== src/cv4a_ctrl.sv =====
// Controller state machine: request handshake and step sequencing.
// Depends on cv4a_pkg.
module cv4a_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  cv4a_pkg::t_stat i_stat,
    output cv4a_pkg::t_cmd  o_cmd
);
    cv4a_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= cv4a_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            cv4a_pkg::ST_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state = cv4a_pkg::ST_RUN;
                end
            end
            cv4a_pkg::ST_RUN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) n_state = cv4a_pkg::ST_COMMIT;
            end
            cv4a_pkg::ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = cv4a_pkg::ST_OUT;
            end
            cv4a_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = cv4a_pkg::ST_IDLE;
            end
            default: n_state = cv4a_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== src/checked_vec4_int64_alu.sv =====
// Top level of the checked four-lane 64-bit vector ALU.
// Instantiates cv4a_ctrl and cv4a_datapath; depends on cv4a_pkg.
//
// Each request is accepted in idle. It then takes 64 single-bit steps of the
// per-lane multiplier and divider and a commit state, for every operation.
// The result is offered after the commit state and holds until taken. A
// new request is accepted only after that, once the controller is back in
// idle. Status 1 means the vector was left unchanged.
module checked_vec4_int64_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_operand_x,
    input  logic [63:0] i_operand_y,
    input  logic [63:0] i_operand_z,
    input  logic [63:0] i_operand_w,
    input  logic        i_keep_x,
    input  logic        i_keep_y,
    input  logic        i_keep_z,
    input  logic        i_keep_w,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [63:0] o_acc_x,
    output logic [63:0] o_acc_y,
    output logic [63:0] o_acc_z,
    output logic [63:0] o_acc_w
);
    cv4a_pkg::t_cmd  cmd;
    cv4a_pkg::t_stat stat;
    logic [cv4a_pkg::Lanes-1:0][63:0] acc;

    cv4a_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cv4a_datapath u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_req_type (i_req_type),
        .i_opnd     ({i_operand_w, i_operand_z, i_operand_y, i_operand_x}),
        .i_keep     ({i_keep_w, i_keep_z, i_keep_y, i_keep_x}),
        .i_rst_n    (i_rst_n),
        .o_stat     (stat),
        .o_status   (o_status),
        .o_acc      (acc)
    );

    assign o_acc_x = acc[0];
    assign o_acc_y = acc[1];
    assign o_acc_z = acc[2];
    assign o_acc_w = acc[3];
endmodule
